// ----- rtl/dwvp_pkg.sv -----
// Shared types, constants and codes for the dual-wheel velocity PID block.
package dwvp_pkg;

    localparam int AVG_TICKS  = 10;
    localparam int TICK_W     = 4;

    localparam int MUL_A_W    = 40;
    localparam int MUL_B_W    = 16;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_DATA_W-1:0] PROP_GAIN_RST  = 32'd1310720;
    localparam logic [CFG_DATA_W-1:0] INTEG_GAIN_RST = 32'd65536;
    localparam logic [CFG_DATA_W-1:0] DERIV_GAIN_RST = 32'd1310720;
    localparam logic [CFG_DATA_W-1:0] STEP_TIME_RST  = 32'd655;
    localparam logic [CFG_DATA_W-1:0] HALF_TRACK_RST = 32'd13107;
    localparam logic [CFG_DATA_W-1:0] SPEED_RPM_RST  = 32'd6258267;

    typedef enum logic [2:0] {
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_DERIV_GAIN,
        REG_STEP_TIME,
        REG_HALF_TRACK,
        REG_SPEED_TO_RPM
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG_HI,
        ST_ANG_LO,
        ST_ANG_SUM,
        ST_RPM_HI,
        ST_RPM_LO,
        ST_RPM_SUM,
        ST_ERR,
        ST_MUL_DT,
        ST_INTEG,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [15:0] left_meas_rpm;
        logic signed [15:0] right_meas_rpm;
        logic               link_timeout;
        logic signed [23:0] cmd_linear;
        logic signed [23:0] cmd_angular;
    } tick_word_t;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic signed [15:0] left_target_rpm;
        logic signed [15:0] right_target_rpm;
        logic               pid_updated;
    } drive_word_t;

endpackage

// ----- rtl/dwvp_mul.sv -----
// Shared unsigned multiplier with registered product.
module dwvp_mul (
    input  logic                         clk,
    input  logic [dwvp_pkg::MUL_A_W-1:0] a,
    input  logic [dwvp_pkg::MUL_B_W-1:0] b,
    output logic [dwvp_pkg::MUL_P_W-1:0] p
);
    import dwvp_pkg::*;

    logic [MUL_P_W-1:0] p_reg;
    logic [MUL_P_W-1:0] p_next;

    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- rtl/dual_wheel_velocity_pid.sv -----
// Top level: dual-wheel velocity PID with averaging, target conversion and APB registers.
//
// One word is taken per control tick and one word is returned for it. For a timeout or
// averaging tick the result is offered in the cycle right after acceptance. A PID tick
// steps the single 40x16 multiplier through the angular term (2 products), the rpm
// conversion (2 per wheel) and the PID (4 per wheel) before its result is offered. A
// result is held while the result side stalls, and a new word is accepted only once the
// previous result has been taken. Registers are written and read over the APB port at
// byte address 4*i and should be written while idle.
module dual_wheel_velocity_pid (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_stall,
    input  dwvp_pkg::tick_word_t            tick_word,
    output logic                            drive_valid,
    input  logic                            drive_stall,
    output dwvp_pkg::drive_word_t           drive_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dwvp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dwvp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dwvp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import dwvp_pkg::*;

    localparam int ACC_W = MUL_P_W + 1;

    function automatic logic signed [15:0] sat_drive(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32766)
            r = 16'sd32766;
        else if (v < -40'sd32766)
            r = -16'sd32766;
        else
            r = 16'(v);
        return r;
    endfunction

    function automatic logic signed [15:0] sat_i16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)
            r = 16'sd32767;
        else if (v < -40'sd32768)
            r = -16'sd32768;
        else
            r = 16'(v);
        return r;
    endfunction

    function automatic logic signed [15:0] half_avg(input logic signed [15:0] m,
                                                    input logic signed [15:0] a);
        logic signed [16:0] s;
        logic signed [16:0] h;
        s = 17'(m) + 17'(a);
        h = (s + (s[16] ? 17'sd1 : 17'sd0)) >>> 1;
        return 16'(h);
    endfunction

    // configuration registers
    logic [CFG_DATA_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [CFG_DATA_W-1:0] step_time_reg, half_track_reg, speed_rpm_reg;
    logic                  cfg_wr;

    // control
    state_t                state_reg, state_next;
    logic                  wheel_reg, wheel_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic                  upd_reg, upd_next;

    // controller state
    logic signed [15:0]    out_reg [2], out_next [2];
    logic signed [15:0]    avg_reg [2], avg_next [2];
    logic signed [15:0]    e_now_reg [2], e_now_next [2];
    logic signed [15:0]    e_prev_reg [2], e_prev_next [2];
    logic signed [15:0]    tgt_reg [2], tgt_next [2];

    // working registers
    logic signed [23:0]    lin_reg, lin_next;
    logic [23:0]           ang_mag_reg, ang_mag_next;
    logic                  ang_neg_reg, ang_neg_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [MUL_A_W-1:0]    v_mag_reg [2], v_mag_next [2];
    logic                  v_neg_reg [2], v_neg_next [2];
    logic signed [15:0]    integ_reg, integ_next;
    logic                  mul_neg_reg, mul_neg_next;

    // multiplier
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]    mul_p;
    logic signed [ACC_W-1:0] prod_s;

    // datapath intermediates
    logic [MUL_A_W-1:0]    am;
    logic signed [41:0]    a_s, lin_x, vl, vr;
    logic [ACC_W-1:0]      r_full;
    logic [40:0]           r_rpm;
    logic signed [15:0]    rpm_sat;
    logic signed [16:0]    tgt17;
    logic signed [17:0]    diff;
    logic signed [15:0]    e_new;
    logic signed [16:0]    esum, de;
    logic [15:0]           esum_mag, de_mag, en_mag, integ_mag;
    logic signed [ACC_W-1:0] num, num_adj, num_q;
    logic signed [ACC_W-1:0] total, tot_adj, tot_q;
    logic [23:0]           cmd_ang_mag;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            step_time_reg  <= STEP_TIME_RST;
            half_track_reg <= HALF_TRACK_RST;
            speed_rpm_reg  <= SPEED_RPM_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(paddr[4:2]))
                REG_PROP_GAIN:    prop_gain_reg  <= pwdata;
                REG_INTEG_GAIN:   integ_gain_reg <= pwdata;
                REG_DERIV_GAIN:   deriv_gain_reg <= pwdata;
                REG_STEP_TIME:    step_time_reg  <= pwdata;
                REG_HALF_TRACK:   half_track_reg <= pwdata;
                REG_SPEED_TO_RPM: speed_rpm_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[4:2]))
            REG_PROP_GAIN:    prdata = prop_gain_reg;
            REG_INTEG_GAIN:   prdata = integ_gain_reg;
            REG_DERIV_GAIN:   prdata = deriv_gain_reg;
            REG_STEP_TIME:    prdata = step_time_reg;
            REG_HALF_TRACK:   prdata = half_track_reg;
            REG_SPEED_TO_RPM: prdata = speed_rpm_reg;
            default:          prdata = '0;
        endcase
    end

    dwvp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign prod_s = mul_neg_reg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});

    // angular term and per-wheel speed
    assign am    = acc_reg[MUL_A_W-1:0] + mul_p[MUL_P_W-1:16];
    assign a_s   = ang_neg_reg ? -$signed({2'b00, am}) : $signed({2'b00, am});
    assign lin_x = 42'(lin_reg);
    assign vl    = lin_x - a_s;
    assign vr    = lin_x + a_s;

    // speed to rpm: (hi + (lo >> 16)) >> 16
    assign r_full = {1'b0, acc_reg[MUL_P_W-1:0]} + ACC_W'(mul_p[MUL_P_W-1:16]);
    assign r_rpm  = r_full[ACC_W-1:16];

    always_comb
    begin
        if (v_neg_reg[wheel_reg])
            rpm_sat = (r_rpm >= 41'd32768) ? -16'sd32768 : -$signed(16'(r_rpm));
        else
            rpm_sat = (r_rpm >= 41'd32767) ? 16'sd32767 : $signed(16'(r_rpm));
    end

    // error; the right wheel runs on the negated target
    assign tgt17 = wheel_reg ? -17'(tgt_reg[1]) : 17'(tgt_reg[0]);
    assign diff  = 18'(tgt17) - 18'(avg_reg[wheel_reg]);
    assign e_new = sat_drive(40'(diff));

    assign esum      = 17'(e_now_reg[wheel_reg]) + 17'(e_prev_reg[wheel_reg]);
    assign de        = 17'(e_now_reg[wheel_reg]) - 17'(e_prev_reg[wheel_reg]);
    assign esum_mag  = esum[16] ? 16'(-esum) : esum[15:0];
    assign de_mag    = de[16] ? 16'(-de) : de[15:0];
    assign en_mag    = e_now_reg[wheel_reg][15] ? 16'(-17'(e_now_reg[wheel_reg]))
                                                 : e_now_reg[wheel_reg];
    assign integ_mag = integ_reg[15] ? 16'(-17'(integ_reg)) : integ_reg;

    // integral: trunc0((out * 2^17 + esum * dt) / 2^17)
    assign num     = (ACC_W'(out_reg[wheel_reg]) <<< 17) + prod_s;
    assign num_adj = num + (num[ACC_W-1] ? ACC_W'(131071) : ACC_W'(0));
    assign num_q   = num_adj >>> 17;

    // drive: trunc0(sum / 2^16)
    assign total   = acc_reg + prod_s;
    assign tot_adj = total + (total[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
    assign tot_q   = tot_adj >>> 16;

    assign cmd_ang_mag = tick_word.cmd_angular[23] ? 24'(-tick_word.cmd_angular)
                                                   : tick_word.cmd_angular;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    if (tick_word.link_timeout || tick_reg < TICK_W'(AVG_TICKS))
                        state_next = ST_OUT;
                    else
                        state_next = ST_ANG_HI;
                end
            end
            ST_ANG_HI:  state_next = ST_ANG_LO;
            ST_ANG_LO:  state_next = ST_ANG_SUM;
            ST_ANG_SUM: state_next = ST_RPM_HI;
            ST_RPM_HI:  state_next = ST_RPM_LO;
            ST_RPM_LO:  state_next = ST_RPM_SUM;
            ST_RPM_SUM: state_next = wheel_reg ? ST_ERR : ST_RPM_HI;
            ST_ERR:     state_next = ST_MUL_DT;
            ST_MUL_DT:  state_next = ST_INTEG;
            ST_INTEG:   state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_SUM;
            ST_SUM:     state_next = wheel_reg ? ST_OUT : ST_ERR;
            ST_OUT:     state_next = drive_stall ? ST_OUT : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // handshake and multiplier operand selection
    always_comb
    begin
        tick_stall   = (state_reg != ST_IDLE);
        drive_valid  = (state_reg == ST_OUT);
        mul_a        = '0;
        mul_b        = '0;
        mul_neg_next = 1'b0;
        case (state_reg)
            ST_ANG_HI:
            begin
                mul_a = MUL_A_W'(ang_mag_reg);
                mul_b = half_track_reg[31:16];
            end
            ST_ANG_LO:
            begin
                mul_a = MUL_A_W'(ang_mag_reg);
                mul_b = half_track_reg[15:0];
            end
            ST_RPM_HI:
            begin
                mul_a = v_mag_reg[wheel_reg];
                mul_b = speed_rpm_reg[31:16];
            end
            ST_RPM_LO:
            begin
                mul_a = v_mag_reg[wheel_reg];
                mul_b = speed_rpm_reg[15:0];
            end
            ST_MUL_DT:
            begin
                mul_a        = MUL_A_W'(step_time_reg);
                mul_b        = esum_mag;
                mul_neg_next = esum[16];
            end
            ST_INTEG:
            begin
                mul_a        = MUL_A_W'(prop_gain_reg);
                mul_b        = en_mag;
                mul_neg_next = e_now_reg[wheel_reg][15];
            end
            ST_MUL_I:
            begin
                mul_a        = MUL_A_W'(integ_gain_reg);
                mul_b        = integ_mag;
                mul_neg_next = integ_reg[15];
            end
            ST_MUL_D:
            begin
                mul_a        = MUL_A_W'(deriv_gain_reg);
                mul_b        = de_mag;
                mul_neg_next = de[16];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        wheel_next   = wheel_reg;
        tick_next    = tick_reg;
        upd_next     = upd_reg;
        out_next     = out_reg;
        avg_next     = avg_reg;
        e_now_next   = e_now_reg;
        e_prev_next  = e_prev_reg;
        tgt_next     = tgt_reg;
        lin_next     = lin_reg;
        ang_mag_next = ang_mag_reg;
        ang_neg_next = ang_neg_reg;
        acc_next     = acc_reg;
        v_mag_next   = v_mag_reg;
        v_neg_next   = v_neg_reg;
        integ_next   = integ_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    wheel_next = 1'b0;
                    if (tick_word.link_timeout)
                    begin
                        tick_next   = '0;
                        upd_next    = 1'b0;
                        out_next    = '{16'sd0, 16'sd0};
                        avg_next    = '{16'sd0, 16'sd0};
                        e_now_next  = '{16'sd0, 16'sd0};
                        e_prev_next = '{16'sd0, 16'sd0};
                        tgt_next    = '{16'sd0, 16'sd0};
                    end
                    else if (tick_reg >= TICK_W'(AVG_TICKS))
                    begin
                        tick_next    = '0;
                        upd_next     = 1'b1;
                        lin_next     = tick_word.cmd_linear;
                        ang_mag_next = cmd_ang_mag;
                        ang_neg_next = tick_word.cmd_angular[23];
                    end
                    else
                    begin
                        tick_next   = tick_reg + TICK_W'(1);
                        upd_next    = 1'b0;
                        avg_next[0] = half_avg(tick_word.left_meas_rpm, avg_reg[0]);
                        avg_next[1] = half_avg(tick_word.right_meas_rpm, avg_reg[1]);
                    end
                end
            end
            ST_ANG_LO:
            begin
                acc_next = $signed({1'b0, mul_p});
            end
            ST_ANG_SUM:
            begin
                v_neg_next[0] = vl[41];
                v_neg_next[1] = vr[41];
                v_mag_next[0] = vl[41] ? MUL_A_W'(-vl) : vl[MUL_A_W-1:0];
                v_mag_next[1] = vr[41] ? MUL_A_W'(-vr) : vr[MUL_A_W-1:0];
            end
            ST_RPM_LO:
            begin
                acc_next = $signed({1'b0, mul_p});
            end
            ST_RPM_SUM:
            begin
                tgt_next[wheel_reg] = rpm_sat;
                wheel_next          = ~wheel_reg;
            end
            ST_ERR:
            begin
                e_prev_next[wheel_reg] = e_now_reg[wheel_reg];
                e_now_next[wheel_reg]  = e_new;
            end
            ST_INTEG:
            begin
                integ_next = sat_i16(40'(num_q));
            end
            ST_MUL_I:
            begin
                acc_next = prod_s;
            end
            ST_MUL_D:
            begin
                acc_next = total;
            end
            ST_SUM:
            begin
                out_next[wheel_reg] = sat_drive(40'(tot_q));
                wheel_next          = ~wheel_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wheel_reg  <= 1'b0;
            tick_reg   <= '0;
            upd_reg    <= 1'b0;
            out_reg    <= '{16'sd0, 16'sd0};
            avg_reg    <= '{16'sd0, 16'sd0};
            e_now_reg  <= '{16'sd0, 16'sd0};
            e_prev_reg <= '{16'sd0, 16'sd0};
            tgt_reg    <= '{16'sd0, 16'sd0};
        end
        else
        begin
            state_reg  <= state_next;
            wheel_reg  <= wheel_next;
            tick_reg   <= tick_next;
            upd_reg    <= upd_next;
            out_reg    <= out_next;
            avg_reg    <= avg_next;
            e_now_reg  <= e_now_next;
            e_prev_reg <= e_prev_next;
            tgt_reg    <= tgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg     <= lin_next;
        ang_mag_reg <= ang_mag_next;
        ang_neg_reg <= ang_neg_next;
        acc_reg     <= acc_next;
        v_mag_reg   <= v_mag_next;
        v_neg_reg   <= v_neg_next;
        integ_reg   <= integ_next;
        mul_neg_reg <= mul_neg_next;
    end

    // result word straight from the controller state
    always_comb
    begin
        drive_word.left_drive       = out_reg[0];
        drive_word.right_drive      = out_reg[1];
        drive_word.left_target_rpm  = tgt_reg[0];
        drive_word.right_target_rpm = tgt_reg[1];
        drive_word.pid_updated      = upd_reg;
    end

endmodule

// ----- tb/dual_wheel_velocity_pid_tb.sv -----
// Self-checking testbench for the dual-wheel velocity PID: predicted drive words vs the block.
module dual_wheel_velocity_pid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dwvp_pkg::*;

    localparam longint DRIVE_LIM   = 32766;
    localparam int     CYCLE_LIMIT = 1_500_000;
    localparam int     TAIL_CYCLES = 30;

    // Predicts the drive word for every accepted tick and checks the block against it.
    class wheel_pid_scoreboard;
        longint kp, ki, kd, dt, track, s2rpm;
        longint l_out, r_out, l_avg, r_avg;
        longint l_e_prev, l_e_now, r_e_prev, r_e_now;
        longint l_tgt, r_tgt;
        int unsigned ticks;
        drive_word_t drives_due[$];
        int errors;

        function new();
            kp     = PROP_GAIN_RST;
            ki     = INTEG_GAIN_RST;
            kd     = DERIV_GAIN_RST;
            dt     = STEP_TIME_RST;
            track  = HALF_TRACK_RST;
            s2rpm  = SPEED_RPM_RST;
            errors = 0;
            clear();
        endfunction

        function void clear();
            l_out = 0; r_out = 0; l_avg = 0; r_avg = 0;
            l_e_prev = 0; l_e_now = 0; r_e_prev = 0; r_e_now = 0;
            l_tgt = 0; r_tgt = 0;
            ticks = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [31:0] v);
            case (r)
                REG_PROP_GAIN:    kp    = v;
                REG_INTEG_GAIN:   ki    = v;
                REG_DERIV_GAIN:   kd    = v;
                REG_STEP_TIME:    dt    = v;
                REG_HALF_TRACK:   track = v;
                REG_SPEED_TO_RPM: s2rpm = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] get_reg(cfg_reg_t r);
            case (r)
                REG_PROP_GAIN:    return kp[31:0];
                REG_INTEG_GAIN:   return ki[31:0];
                REG_DERIV_GAIN:   return kd[31:0];
                REG_STEP_TIME:    return dt[31:0];
                REG_HALF_TRACK:   return track[31:0];
                REG_SPEED_TO_RPM: return s2rpm[31:0];
                default:          return '0;
            endcase
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // speed times S / 2^32, truncated toward zero, saturated to 16 bits
        function longint rpm_of(longint v);
            longint m, hi, lo, r;
            m  = v < 0 ? -v : v;
            hi = m * (s2rpm >> 16);
            lo = m * (s2rpm & 64'hFFFF);
            r  = (hi + (lo >> 16)) >> 16;
            if (v < 0)
                return r >= 32768 ? -32768 : -r;
            return r >= 32767 ? 32767 : r;
        endfunction

        function longint pid_step(longint prev, longint fb, longint tgt,
                                  inout longint e_prev, inout longint e_now);
            longint e, num, integ, sum;
            e_prev = e_now;
            e      = sat(tgt - fb, -DRIVE_LIM, DRIVE_LIM);
            e_now  = e;
            num    = prev * 131072 + (e_now + e_prev) * dt;
            integ  = sat(num / 131072, -32768, 32767);
            sum    = kp * e + ki * integ + kd * (e_now - e_prev);
            return sat(sum / 65536, -DRIVE_LIM, DRIVE_LIM);
        endfunction

        function void note_tick(tick_word_t w);
            longint lm, rm, lin, ang, am, a;
            bit upd;
            drive_word_t want;
            lm  = $signed(w.left_meas_rpm);
            rm  = $signed(w.right_meas_rpm);
            lin = $signed(w.cmd_linear);
            ang = $signed(w.cmd_angular);
            upd = 1'b0;
            if (w.link_timeout) begin
                clear();
            end
            else if (ticks >= AVG_TICKS) begin
                am    = ((ang < 0 ? -ang : ang) * track) >> 16;
                a     = ang < 0 ? -am : am;
                l_tgt = rpm_of(lin - a);
                r_tgt = rpm_of(lin + a);
                l_out = pid_step(l_out, l_avg, l_tgt, l_e_prev, l_e_now);
                // right wheel runs mirrored
                r_out = pid_step(r_out, r_avg, -r_tgt, r_e_prev, r_e_now);
                ticks = 0;
                upd   = 1'b1;
            end
            else begin
                l_avg = (lm + l_avg) / 2;
                r_avg = (rm + r_avg) / 2;
                ticks = (ticks + 1) & 15;
            end
            want.left_drive       = l_out[15:0];
            want.right_drive      = r_out[15:0];
            want.left_target_rpm  = l_tgt[15:0];
            want.right_target_rpm = r_tgt[15:0];
            want.pid_updated      = upd;
            drives_due.push_back(want);
        endfunction

        function void cmp(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function void check_drive(drive_word_t got);
            drive_word_t want;
            if (drives_due.size() == 0) begin
                $error("drive word with nothing outstanding");
                errors++;
                return;
            end
            want = drives_due.pop_front();
            cmp("left_drive", want.left_drive, got.left_drive);
            cmp("right_drive", want.right_drive, got.right_drive);
            cmp("left_target_rpm", want.left_target_rpm, got.left_target_rpm);
            cmp("right_target_rpm", want.right_target_rpm, got.right_target_rpm);
            cmp("pid_updated", 16'(want.pid_updated), 16'(got.pid_updated));
        endfunction

        function int pending();
            return drives_due.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  tick_valid;
    logic                  tick_stall;
    tick_word_t            tick_word;
    logic                  drive_valid;
    logic                  drive_stall;
    drive_word_t           drive_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wheel_pid_scoreboard sb;
    int  cycles = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    dual_wheel_velocity_pid uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .tick_word   (tick_word),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_word  (drive_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && drive_valid && !drive_stall)
            sb.check_drive(drive_word);
    end

    // mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 90)
            return $urandom_range(3, 8);
        return $urandom_range(15, 60);
    endfunction

    initial
    begin
        int hold;
        hold = 0;
        drive_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && !rx_calm && $urandom_range(0, 99) < 25)
                hold = gap_len();
            drive_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    task automatic send_tick(input tick_word_t w);
        int gap;
        gap = (!tx_calm && $urandom_range(0, 99) < 40) ? gap_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            tick_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        tick_valid <= 1'b1;
        tick_word  <= w;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        sb.note_tick(w);
    endtask

    task automatic stop_ticks();
        @(negedge clk);
        tick_valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input cfg_reg_t r, input bit wr, input logic [31:0] v,
                              output logic [31:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input cfg_reg_t r);
        logic [31:0] rd;
        apb_access(r, 1'b0, '0, rd);
        if (rd !== sb.get_reg(r))
        begin
            $error("%s readback: expected %0h, got %0h", r.name(), sb.get_reg(r), rd);
            sb.errors++;
        end
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        logic [31:0] rd;
        apb_access(r, 1'b1, v, rd);
        sb.set_reg(r, v);
        check_reg(r);
    endtask

    task automatic load_gains(input logic [31:0] p, i, d, t, h, s);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_STEP_TIME, t);
        write_reg(REG_HALF_TRACK, h);
        write_reg(REG_SPEED_TO_RPM, s);
    endtask

    function automatic tick_word_t mk_tick(logic [15:0] lm, logic [15:0] rm, bit timeout,
                                           logic [23:0] lin, logic [23:0] ang);
        tick_word_t w;
        w.left_meas_rpm  = lm;
        w.right_meas_rpm = rm;
        w.link_timeout   = timeout;
        w.cmd_linear     = lin;
        w.cmd_angular    = ang;
        return w;
    endfunction

    function automatic logic [15:0] rand_rpm();
        if ($urandom_range(0, 99) < 35)
            return 16'($urandom);
        return 16'($urandom_range(0, 6000) - 3000);
    endfunction

    function automatic logic [23:0] rand_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 24'h7FFFFF;
        if (r < 10)
            return 24'h800000;
        if (r < 40)
            return 24'($urandom);
        return 24'($urandom_range(0, 1 << 19) - (1 << 18));
    endfunction

    function automatic logic [31:0] rand_gain(logic [31:0] nominal);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 45)
            return $urandom;
        return $urandom_range(0, nominal * 4);
    endfunction

    // non-timeout ticks, averaging while the count allows, with the measurement fields at their extremes
    task automatic avg_extremes(input int n);
        for (int k = 0; k < n; k++)
        begin
            if (k % 2 == 0)
                send_tick(mk_tick(16'h7FFF, 16'h8000, 1'b0, 24'h7FFFFF, 24'h800000));
            else
                send_tick(mk_tick(16'h8000, 16'h7FFF, 1'b0, 24'h800000, 24'h7FFFFF));
        end
    endtask

    task automatic run_random(input int n);
        tick_word_t w;
        for (int k = 0; k < n; k++)
        begin
            if (k % 50 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            w = mk_tick(rand_rpm(), rand_rpm(), $urandom_range(0, 99) < 3,
                        rand_cmd(), rand_cmd());
            send_tick(w);
        end
        stop_ticks();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n      = 1'b0;
        tick_valid = 1'b0;
        tick_word  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_reg(REG_PROP_GAIN);
        check_reg(REG_INTEG_GAIN);
        check_reg(REG_DERIV_GAIN);
        check_reg(REG_STEP_TIME);
        check_reg(REG_HALF_TRACK);
        check_reg(REG_SPEED_TO_RPM);

        // reset gains: timeout first, a full averaging run, a PID word, then timeout mid-count
        send_tick(mk_tick(16'h7FFF, 16'h8000, 1'b1, 24'h7FFFFF, 24'h800000));
        avg_extremes(AVG_TICKS);
        send_tick(mk_tick(16'h0000, 16'hFFFF, 1'b0, 24'h7FFFFF, 24'h800000));
        avg_extremes(3);
        send_tick(mk_tick(16'h1234, 16'hEDCB, 1'b1, 24'h000000, 24'hFFFFFF));
        stop_ticks();
        run_random(220);

        // every register at its top; on a PID tick the targets saturate, right one at -32768 before negation
        settle();
        load_gains('1, '1, '1, '1, '1, '1);
        avg_extremes(AVG_TICKS);
        send_tick(mk_tick(16'h0000, 16'h0000, 1'b0, 24'h800000, 24'h800000));
        stop_ticks();
        run_random(200);

        settle();
        load_gains('0, '0, '0, '0, '0, '0);
        run_random(150);

        repeat (6)
        begin
            settle();
            load_gains(rand_gain(PROP_GAIN_RST), rand_gain(INTEG_GAIN_RST),
                       rand_gain(DERIV_GAIN_RST), rand_gain(STEP_TIME_RST),
                       rand_gain(HALF_TRACK_RST), rand_gain(SPEED_RPM_RST));
            run_random(210);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d drive words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- dual_wheel_velocity_pid.f -----
rtl/dwvp_pkg.sv
rtl/dwvp_mul.sv
rtl/dual_wheel_velocity_pid.sv
tb/dual_wheel_velocity_pid_tb.sv
